[src/ssdw_pkg.sv]
// ----------------------------------------------------------------------------
// ssdw_pkg
// Shared constants and types of the seven-segment decimal writer: register
// indexes, controller codes and the command/status bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package ssdw_pkg;

  // sizes
  localparam int unsigned MAX_DIGITS = 8;
  localparam int unsigned MAX_GROUPS = 4;
  localparam int unsigned MAP_W      = 36;
  localparam int unsigned ADDR_W     = 4;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned CFG_IDX_W  = 3;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ZERO  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_ONE   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_TWO   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GROUP_THREE = 3'd4;

  // register reset values
  localparam logic [2:0]       GROUP_COUNT_RST = 3'd3;
  localparam logic [MAP_W-1:0] MAP_ZERO_RST    = 36'd530;
  localparam logic [MAP_W-1:0] MAP_ONE_RST     = 36'd21555;
  localparam logic [MAP_W-1:0] MAP_TWO_RST     = 36'd34659;
  localparam logic [MAP_W-1:0] MAP_THREE_RST   = 36'd0;

  // controller register codes and data bytes
  localparam logic [ADDR_W-1:0] DECODE_ADDR = 4'd9;
  localparam logic [DATA_W-1:0] DECODE_ALL  = 8'hff;
  localparam logic [DATA_W-1:0] POINT_BIT   = 8'd128;
  localparam logic [DATA_W-1:0] BLANK_CODE  = 8'd15;
  localparam logic [DATA_W-1:0] MINUS_CODE  = 8'd1;
  localparam logic [3:0]        MAX_COUNT   = 4'd8;

  // divide by ten: x / 10 == (x * 52429) >> 19, exact for x below 81920
  localparam logic [15:0] DIV10_MUL   = 16'd52429;
  localparam int unsigned DIV10_SHIFT = 19;

  typedef logic [MAX_GROUPS-1:0][MAP_W-1:0] map_arr_t;

  // controller to datapath
  typedef struct packed {
    logic load;        // capture a new transaction
    logic emit_err;    // error result
    logic emit_pre;    // decode-mode write ahead of a position
    logic emit_dig;    // digit write, advance one position
    logic emit_final;  // closing decode-mode write
  } ssdw_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic can_emit;    // output register free or draining
    logic err;         // group not valid
    logic count_zero;  // group has no digits
    logic zero_case;   // zero with no point
    logic need_pre;    // current position needs a decode write first
    logic last_pos;    // current position is the final one
  } ssdw_sts_t;

endpackage

`default_nettype wire

[src/seven_segment_decimal_writer_core.sv]
// ----------------------------------------------------------------------------
// seven_segment_decimal_writer_core
// Turns a signed value into register writes for a code-B seven-segment
// controller digit group.
// ----------------------------------------------------------------------------
// One transaction at a time. After a transaction is taken, a load step looks
// up the group, then each digit position has a slot for a possible
// decode-mode write and then the digit write, with a closing decode write
// for a plain zero; an invalid group gives one error result. A stalled
// output holds the sequence, as the controller waits on the single output
// register. The next transaction is taken as soon as the controller is back
// in idle, even while the final result still waits in the output register.
// There is no reset sweep; configuration registers reset to their defaults.
// ----------------------------------------------------------------------------
`default_nettype none

module seven_segment_decimal_writer_core
  import ssdw_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [MAP_W-1:0]     cfg_wdata_i,
  input  wire logic                 in_valid_i,
  output logic                      in_stall_o,
  input  wire logic [1:0]           group_i,
  input  wire logic [VALUE_W-1:0]   value_i,
  input  wire logic [3:0]           point_pos_i,
  output logic                      out_valid_o,
  input  wire logic                 out_stall_i,
  output logic [ADDR_W-1:0]         reg_address_o,
  output logic [DATA_W-1:0]         reg_data_o,
  output logic                      error_o,
  output logic                      last_o
);

  logic [2:0] group_count;
  map_arr_t   maps;
  ssdw_cmd_t  cmd;
  ssdw_sts_t  sts;

  // configuration registers
  ssdw_regs u_regs (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .group_count_o(group_count),
    .maps_o       (maps)
  );

  // controller
  ssdw_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_stall_o(in_stall_o),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  // datapath
  ssdw_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .group_count_i(group_count),
    .maps_i       (maps),
    .group_i      (group_i),
    .value_i      (value_i),
    .point_pos_i  (point_pos_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .reg_address_o(reg_address_o),
    .reg_data_o   (reg_data_o),
    .error_o      (error_o),
    .last_o       (last_o)
  );

endmodule

`default_nettype wire

[src/ssdw_regs.sv]
// ----------------------------------------------------------------------------
// ssdw_regs
// Configuration register bank: group count and the four digit maps.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdw_regs
  import ssdw_pkg::*;
(
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input  wire logic [MAP_W-1:0]     cfg_wdata_i,
  output logic [2:0]                group_count_o,
  output map_arr_t                  maps_o
);

  logic [2:0] group_count_q;
  map_arr_t   maps_q;

  // register writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      group_count_q <= GROUP_COUNT_RST;
      maps_q[0]     <= MAP_ZERO_RST;
      maps_q[1]     <= MAP_ONE_RST;
      maps_q[2]     <= MAP_TWO_RST;
      maps_q[3]     <= MAP_THREE_RST;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_GROUP_COUNT: group_count_q <= cfg_wdata_i[2:0];
        REG_GROUP_ZERO:  maps_q[0]     <= cfg_wdata_i;
        REG_GROUP_ONE:   maps_q[1]     <= cfg_wdata_i;
        REG_GROUP_TWO:   maps_q[2]     <= cfg_wdata_i;
        REG_GROUP_THREE: maps_q[3]     <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign group_count_o = group_count_q;
  assign maps_o        = maps_q;

endmodule

`default_nettype wire

[src/ssdw_datapath.sv]
// ----------------------------------------------------------------------------
// ssdw_datapath
// Transaction registers, digit extraction by ten and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdw_datapath
  import ssdw_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic [2:0]         group_count_i,
  input  map_arr_t                maps_i,
  input  wire logic [1:0]         group_i,
  input  wire logic [VALUE_W-1:0] value_i,
  input  wire logic [3:0]         point_pos_i,
  input  ssdw_cmd_t               cmd_i,
  output ssdw_sts_t               sts_o,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [ADDR_W-1:0]       reg_address_o,
  output logic [DATA_W-1:0]       reg_data_o,
  output logic                    error_o,
  output logic                    last_o
);

  // transaction registers
  logic [31:0]        map_q;
  logic [3:0]         count_q;
  logic [3:0]         point_q;
  logic [VALUE_W-1:0] mag_q;
  logic               neg_pend_q;
  logic               pos_q;
  logic               zero_case_q;
  logic               err_q;
  logic [2:0]         idx_q;

  // output register
  logic               out_valid_q;
  logic [ADDR_W-1:0]  addr_q, addr_d;
  logic [DATA_W-1:0]  data_q, data_d;
  logic               err_out_q, err_out_d;
  logic               last_q, last_d;

  // load-time values
  logic [MAP_W-1:0]   sel_map;
  logic [3:0]         sel_count;
  logic [VALUE_W-1:0] raw;
  logic [VALUE_W-1:0] mag_in;

  // per-position values
  logic [ADDR_W-1:0]  pos_addr;
  logic               mag_zero;
  logic               pt_cover;
  logic [2:0]         mask_sh;
  logic [DATA_W-1:0]  minus_mask;
  logic [DATA_W-1:0]  pre_data;
  logic [DATA_W-1:0]  dig_data;
  logic [31:0]        prod;
  logic [VALUE_W-1:0] quot;
  logic [VALUE_W-1:0] quot10;
  logic [VALUE_W-1:0] rem_full;
  logic               emit;

  // selection at load
  assign sel_map   = maps_i[group_i];
  assign sel_count = (sel_map[3:0] > MAX_COUNT) ? MAX_COUNT : sel_map[3:0];
  assign raw       = value_i;
  assign mag_in    = raw[VALUE_W-1] ? (16'd0 - raw) : raw;

  // current position
  assign pos_addr = map_q[{idx_q, 2'b00} +: ADDR_W];
  assign mag_zero = (mag_q == 16'd0);
  assign pt_cover = (point_q >= {1'b0, idx_q});

  // decode mask for the minus digit
  assign mask_sh = 3'(pos_addr - 4'd1);
  always_comb begin
    minus_mask = DECODE_ALL;
    if (pos_addr inside {[4'd1:4'd8]}) begin
      minus_mask = DECODE_ALL & ~(8'd1 << mask_sh);
    end
  end
  assign pre_data = neg_pend_q ? minus_mask : DECODE_ALL;

  // divide by ten via reciprocal multiply
  assign prod     = {16'd0, mag_q} * {16'd0, DIV10_MUL};
  assign quot     = {3'd0, prod[31:DIV10_SHIFT]};
  assign quot10   = (quot << 3) + (quot << 1);
  assign rem_full = mag_q - quot10;

  // digit byte
  always_comb begin
    if (zero_case_q) begin
      dig_data = (idx_q == 3'd0) ? 8'd0 : BLANK_CODE;
    end else if (mag_zero && pt_cover) begin
      dig_data = (point_q > {1'b0, idx_q}) ? 8'd0 : POINT_BIT;
    end else if (mag_zero) begin
      dig_data = neg_pend_q ? MINUS_CODE : BLANK_CODE;
    end else begin
      dig_data = {4'd0, rem_full[3:0]};
      if ((point_q == {1'b0, idx_q}) && (point_q != 4'd0)) begin
        dig_data = dig_data | POINT_BIT;
      end
    end
  end

  // status to controller
  assign sts_o.can_emit   = !out_valid_q || !out_stall_i;
  assign sts_o.err        = err_q;
  assign sts_o.count_zero = (count_q == 4'd0);
  assign sts_o.zero_case  = zero_case_q;
  assign sts_o.need_pre   = !zero_case_q && mag_zero && !pt_cover && (neg_pend_q || pos_q);
  assign sts_o.last_pos   = ({1'b0, idx_q} == (count_q - 4'd1));

  // transaction state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      neg_pend_q  <= 1'b0;
      pos_q       <= 1'b0;
      zero_case_q <= 1'b0;
      err_q       <= 1'b0;
      idx_q       <= 3'd0;
      count_q     <= 4'd0;
    end else if (cmd_i.load) begin
      neg_pend_q  <= raw[VALUE_W-1];
      pos_q       <= !raw[VALUE_W-1];
      zero_case_q <= (raw == 16'd0) && (point_pos_i == 4'd0);
      err_q       <= ({1'b0, group_i} >= group_count_i);
      idx_q       <= 3'd0;
      count_q     <= sel_count;
    end else if (cmd_i.emit_dig) begin
      idx_q <= idx_q + 3'd1;
      if (!zero_case_q && mag_zero && !pt_cover) begin
        neg_pend_q <= 1'b0;
      end
    end
  end

  // payload of the transaction
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      map_q   <= sel_map[MAP_W-1:4];
      point_q <= point_pos_i;
      mag_q   <= mag_in;
    end else if (cmd_i.emit_dig && !mag_zero) begin
      mag_q <= quot;
    end
  end

  // next result
  assign emit = cmd_i.emit_err || cmd_i.emit_pre || cmd_i.emit_dig || cmd_i.emit_final;
  always_comb begin
    addr_d    = DECODE_ADDR;
    data_d    = DECODE_ALL;
    err_out_d = 1'b0;
    last_d    = 1'b0;
    if (cmd_i.emit_err) begin
      addr_d    = '0;
      data_d    = '0;
      err_out_d = 1'b1;
      last_d    = 1'b1;
    end else if (cmd_i.emit_pre) begin
      data_d = pre_data;
    end else if (cmd_i.emit_dig) begin
      addr_d = pos_addr;
      data_d = dig_data;
      last_d = sts_o.last_pos && !zero_case_q;
    end else if (cmd_i.emit_final) begin
      last_d = 1'b1;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      addr_q    <= addr_d;
      data_q    <= data_d;
      err_out_q <= err_out_d;
      last_q    <= last_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign reg_address_o = addr_q;
  assign reg_data_o    = data_q;
  assign error_o       = err_out_q;
  assign last_o        = last_q;

endmodule

`default_nettype wire

[src/ssdw_ctrl.sv]
// ----------------------------------------------------------------------------
// ssdw_ctrl
// Controller: sequences error, decode and digit writes for one transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdw_ctrl
  import ssdw_pkg::*;
(
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_stall_o,
  input  ssdw_sts_t sts_i,
  output ssdw_cmd_t cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_LOAD  = 6'b000010,
    S_ERR   = 6'b000100,
    S_PRE   = 6'b001000,
    S_DIG   = 6'b010000,
    S_FINAL = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_LOAD;
        end
      end
      S_LOAD: begin
        if (sts_i.err) begin
          state_d = S_ERR;
        end else if (sts_i.count_zero) begin
          state_d = sts_i.zero_case ? S_FINAL : S_IDLE;
        end else begin
          state_d = S_PRE;
        end
      end
      S_ERR: begin
        if (sts_i.can_emit) begin
          cmd_o.emit_err = 1'b1;
          state_d        = S_IDLE;
        end
      end
      S_PRE: begin
        if (!sts_i.need_pre) begin
          state_d = S_DIG;
        end else if (sts_i.can_emit) begin
          cmd_o.emit_pre = 1'b1;
          state_d        = S_DIG;
        end
      end
      S_DIG: begin
        if (sts_i.can_emit) begin
          cmd_o.emit_dig = 1'b1;
          if (!sts_i.last_pos) begin
            state_d = S_PRE;
          end else if (sts_i.zero_case) begin
            state_d = S_FINAL;
          end else begin
            state_d = S_IDLE;
          end
        end
      end
      S_FINAL: begin
        if (sts_i.can_emit) begin
          cmd_o.emit_final = 1'b1;
          state_d          = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q != S_IDLE);

endmodule

`default_nettype wire

[src/ssdw_checker.sv]
// ----------------------------------------------------------------------------
// ssdw_checker
// Port-level checks of the seven-segment decimal writer, bound to the top.
// ----------------------------------------------------------------------------
`default_nettype none

module ssdw_checker
  import ssdw_pkg::*;
(
  input wire logic                 clk_i,
  input wire logic                 rst_ni,
  input wire logic                 cfg_we_i,
  input wire logic [CFG_IDX_W-1:0] cfg_index_i,
  input wire logic [MAP_W-1:0]     cfg_wdata_i,
  input wire logic                 in_valid_i,
  input wire logic                 in_stall_o,
  input wire logic [1:0]           group_i,
  input wire logic [VALUE_W-1:0]   value_i,
  input wire logic [3:0]           point_pos_i,
  input wire logic                 out_valid_o,
  input wire logic                 out_stall_i,
  input wire logic [ADDR_W-1:0]    reg_address_o,
  input wire logic [DATA_W-1:0]    reg_data_o,
  input wire logic                 error_o,
  input wire logic                 last_o
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(reg_address_o)
      && $stable(reg_data_o) && $stable(error_o) && $stable(last_o))
    else $error("stalled result changed");

  // an error result is a single, empty, final transaction
  a_err_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && error_o |-> last_o && (reg_address_o == '0) && (reg_data_o == '0))
    else $error("error result malformed");

  // one transaction in flight: no accept right after an accept
  a_one_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("accepted back to back");

  // no result shows out of reset
  a_reset_empty: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !out_valid_o)
    else $error("result valid out of reset");

endmodule

bind seven_segment_decimal_writer_core ssdw_checker u_checker (.*);

`default_nettype wire
